// ===== hw/rtl/edtp_pkg.sv =====
// Shared constants for the extended date text parser.
// No dependencies; compiled first.
`default_nettype none

package edtp_pkg;

   // default widths of the parsed values and the byte count
   localparam int VALUE_BITS_DEF = 32;
   localparam int COUNT_BITS_DEF = 16;

   // characters and digit arithmetic
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] DIGIT_MAX  = 8'd9;
   localparam int         RADIX      = 10;

   // field being parsed
   localparam logic [1:0] FIELD_YEAR  = 2'd0;
   localparam logic [1:0] FIELD_MONTH = 2'd1;
   localparam logic [1:0] FIELD_DAY   = 2'd2;
   localparam logic [1:0] FIELD_IDLE  = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/edtp_chan_if.sv =====
// Valid/ready channel interfaces for the date parser: text bytes in, dates out.
// Depends on edtp_pkg for the default widths.
`default_nettype none

interface edtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       first_byte;

   modport source (output valid, output char_byte, output first_byte, input ready);
   modport sink   (input valid, input char_byte, input first_byte, output ready);
endinterface

interface edtp_rsp_if #(
   parameter int VALUE_BITS = edtp_pkg::VALUE_BITS_DEF,
   parameter int COUNT_BITS = edtp_pkg::COUNT_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] year;
   logic signed [VALUE_BITS-1:0] month;
   logic signed [VALUE_BITS-1:0] day;
   logic        [COUNT_BITS-1:0] consumed;
   logic                         ok;

   modport source (output valid, output year, output month, output day,
                   output consumed, output ok, input ready);
   modport sink   (input valid, input year, input month, input day,
                   input consumed, input ok, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/extended_date_text_parser.sv =====
// Extended date text parser, [-]Y-[-]M-[-]D, one text byte per request.
// Depends on edtp_pkg and the channel interfaces in edtp_chan_if.sv.
//
// Usage:
//   req_port carries one text byte and a first_byte flag; first_byte = 1
//   restarts the parse at that byte. Bytes before the first flag after reset,
//   and bytes after a parse has ended, are dropped without a response.
//   rsp_port carries year, month, day, the consumed byte count and ok. One
//   response comes for the byte that ends a parse: the first non-digit after
//   the day, or a year/month terminator that is not '-' (ok = 0, consumed 0).
//   Path: a request is registered, then parsed by a single multiply-by-ten
//   accumulate as it leaves the input register, and the response is registered.
//   Throughput: one request per cycle while responses are taken, set by
//   the per-byte accumulate loop through the parse state registers.
//   Stall: while a response waits, one more request is taken into the input
//   register; ready drops only when both registers are full and the output
//   is not taken.
//   Reset (synchronous, active high) empties both registers and puts the
//   parser into its idle state.
`default_nettype none

module extended_date_text_parser #(
   parameter int VALUE_BITS = edtp_pkg::VALUE_BITS_DEF,
   parameter int COUNT_BITS = edtp_pkg::COUNT_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   edtp_req_if.sink    req_port,
   edtp_rsp_if.source  rsp_port
);
   import edtp_pkg::*;

   localparam logic [VALUE_BITS-1:0] RADIX_V   = VALUE_BITS'(RADIX);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_first_ff;

   // parse state
   logic [1:0]            field_ff, field_in;
   logic                  start_ff, start_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] year_ff, year_in;
   logic [VALUE_BITS-1:0] month_ff, month_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // response register
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_year_ff, out_month_ff, out_day_ff;
   logic [VALUE_BITS-1:0] res_month, res_day;
   logic [COUNT_BITS-1:0] out_count_ff, res_count;
   logic                  out_ok_ff, res_ok;

   logic                  advance, emit, take_req;
   logic [1:0]            field_e;
   logic                  start_e, neg_e;
   logic [VALUE_BITS-1:0] acc_e, year_e, month_e, value;
   logic [COUNT_BITS-1:0] count_e, count_inc;
   logic [7:0]            digit_off;
   logic                  is_digit, is_minus;

   assign advance  = s1_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !s1_valid_ff || advance;
   assign take_req = req_port.valid && req_port.ready;

   // state seen by this byte: a first byte restarts everything
   always_comb begin
      if (s1_first_ff) begin
         field_e = FIELD_YEAR;
         start_e = 1'b1;
         neg_e   = 1'b0;
         acc_e   = '0;
         year_e  = '0;
         month_e = '0;
         count_e = '0;
      end else begin
         field_e = field_ff;
         start_e = start_ff;
         neg_e   = neg_ff;
         acc_e   = acc_ff;
         year_e  = year_ff;
         month_e = month_ff;
         count_e = count_ff;
      end
   end

   assign digit_off = s1_char_ff - CHAR_ZERO;
   assign is_digit  = digit_off <= DIGIT_MAX;
   assign is_minus  = s1_char_ff == CHAR_MINUS;
   assign value     = neg_e ? (VALUE_BITS'(0) - acc_e) : acc_e;
   assign count_inc = (count_e == COUNT_MAX) ? count_e : count_e + 1'b1;

   always_comb begin
      field_in  = field_e;
      start_in  = start_e;
      neg_in    = neg_e;
      acc_in    = acc_e;
      year_in   = year_e;
      month_in  = month_e;
      count_in  = count_e;
      emit      = 1'b0;
      res_month = '0;
      res_day   = '0;
      res_count = '0;
      res_ok    = 1'b0;
      if (field_e != FIELD_IDLE) begin
         if (start_e && is_minus) begin
            start_in = 1'b0;
            neg_in   = 1'b1;
            count_in = count_inc;
         end else if (is_digit) begin
            start_in = 1'b0;
            acc_in   = acc_e * RADIX_V + VALUE_BITS'(digit_off[3:0]);
            count_in = count_inc;
         end else if (field_e != FIELD_DAY) begin
            start_in = 1'b0;
            if (field_e == FIELD_YEAR) begin
               year_in = value;
            end else begin
               month_in = value;
            end
            if (is_minus) begin
               field_in = field_e + 1'b1;
               start_in = 1'b1;
               neg_in   = 1'b0;
               acc_in   = '0;
               count_in = count_inc;
            end else begin
               // missing separator: report what was parsed so far
               emit     = 1'b1;
               field_in = FIELD_IDLE;
               if (field_e == FIELD_MONTH) begin
                  res_month = value;
               end
            end
         end else begin
            start_in  = 1'b0;
            emit      = 1'b1;
            field_in  = FIELD_IDLE;
            res_month = month_e;
            res_day   = value;
            res_count = count_e;
            res_ok    = 1'b1;
         end
      end
   end

   assign s1_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = (advance && emit) ? 1'b1
                       : (rsp_port.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         field_ff     <= FIELD_IDLE;
         start_ff     <= 1'b1;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            field_ff <= field_in;
            start_ff <= start_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            year_ff  <= year_in;
            month_ff <= month_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_char_ff  <= req_port.char_byte;
         s1_first_ff <= req_port.first_byte;
      end
      if (advance && emit) begin
         out_year_ff  <= year_in;
         out_month_ff <= res_month;
         out_day_ff   <= res_day;
         out_count_ff <= res_count;
         out_ok_ff    <= res_ok;
      end
   end

   assign rsp_port.valid    = out_valid_ff;
   assign rsp_port.year     = $signed(out_year_ff);
   assign rsp_port.month    = $signed(out_month_ff);
   assign rsp_port.day      = $signed(out_day_ff);
   assign rsp_port.consumed = out_count_ff;
   assign rsp_port.ok       = out_ok_ff;

   // a failed parse never reports a byte count
   a_fail_count: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.ok |-> rsp_port.consumed == '0)
      else $error("failed parse with nonzero consumed count");

   // a response ends the parse
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> field_ff == FIELD_IDLE)
      else $error("parser not idle after response");

   // a restart that does not end at once leaves the parser active
   a_first_active: assert property (@(posedge clock) disable iff (reset)
      advance && s1_first_ff && !emit |=> field_ff != FIELD_IDLE)
      else $error("restart byte left the parser idle");

   // input stalls only when both registers are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> s1_valid_ff && out_valid_ff && !rsp_port.ready)
      else $error("input stalled with room available");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for extended_date_text_parser: directed and random date text.
// Depends on edtp_pkg and the channel interfaces in edtp_chan_if.sv.

module testbench;
   import edtp_pkg::*;

   localparam int QUIET_LIMIT = 1000;

   typedef struct {
      logic signed [VALUE_BITS_DEF-1:0] year;
      logic signed [VALUE_BITS_DEF-1:0] month;
      logic signed [VALUE_BITS_DEF-1:0] day;
      logic        [COUNT_BITS_DEF-1:0] consumed;
      logic                             ok;
   } date_type;

   // Tracks the parse of the text stream and the dates it must produce.
   class date_scoreboard_type;
      logic [1:0]                field_sel;
      bit                        at_start;
      bit                        minus;
      logic [VALUE_BITS_DEF-1:0] acc;
      logic [VALUE_BITS_DEF-1:0] year_val;
      logic [VALUE_BITS_DEF-1:0] month_val;
      logic [COUNT_BITS_DEF-1:0] count;
      date_type                  dates_q[$];
      int                        errors;
      int                        parsed;

      function new();
         field_sel = FIELD_IDLE;
         clear_field();
         year_val  = '0;
         month_val = '0;
         count     = '0;
         errors    = 0;
         parsed    = 0;
      endfunction

      function void clear_field();
         at_start = 1'b1;
         minus    = 1'b0;
         acc      = '0;
      endfunction

      function void bump_count();
         if (count != '1) count++;
      endfunction

      function int pending();
         return dates_q.size();
      endfunction

      function void note_request(logic [7:0] c, logic first);
         date_type                  d;
         logic [VALUE_BITS_DEF-1:0] v;
         parsed++;
         if (first) begin
            field_sel = FIELD_YEAR;
            clear_field();
            year_val  = '0;
            month_val = '0;
            count     = '0;
         end
         if (field_sel == FIELD_IDLE) return;
         if (at_start && c == CHAR_MINUS) begin
            at_start = 1'b0;
            minus    = 1'b1;
            bump_count();
            return;
         end
         at_start = 1'b0;
         if (c >= CHAR_ZERO && c <= CHAR_ZERO + DIGIT_MAX) begin
            acc = acc * RADIX + VALUE_BITS_DEF'(c - CHAR_ZERO);
            bump_count();
            return;
         end
         v = minus ? -acc : acc;
         if (field_sel == FIELD_DAY) begin
            d.year     = year_val;
            d.month    = month_val;
            d.day      = v;
            d.consumed = count;
            d.ok       = 1'b1;
         end else begin
            if (field_sel == FIELD_YEAR) year_val = v;
            else month_val = v;
            if (c == CHAR_MINUS) begin
               field_sel = field_sel + 2'd1;
               clear_field();
               bump_count();
               return;
            end
            // missing separator: keep what was parsed so far, zero the rest
            d.year     = year_val;
            d.month    = (field_sel == FIELD_MONTH) ? month_val : '0;
            d.day      = '0;
            d.consumed = '0;
            d.ok       = 1'b0;
         end
         field_sel = FIELD_IDLE;
         dates_q.push_back(d);
      endfunction

      function void check_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(date_type got);
         date_type want;
         if (dates_q.size() == 0) begin
            $display("%0t: unexpected date, expected none actual year %0d ok %0d",
                     $time, got.year, got.ok);
            errors++;
            return;
         end
         want = dates_q.pop_front();
         check_field("year", want.year, got.year);
         check_field("month", want.month, got.month);
         check_field("day", want.day, got.day);
         check_field("consumed", want.consumed, got.consumed);
         check_field("ok", want.ok, got.ok);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int   quiet_cycles = 0;
   logic [7:0] text_q[$];
   date_scoreboard_type sb = new();

   edtp_req_if req_if ();
   edtp_rsp_if rsp_if ();

   extended_date_text_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if.sink),
      .rsp_port (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.char_byte  = 8'h00;
      req_if.first_byte = 1'b0;
      rsp_if.ready      = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= calm || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_request(req_if.char_byte, req_if.first_byte);
   end

   always @(posedge clock) begin
      date_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.year     = rsp_if.year;
         got.month    = rsp_if.month;
         got.day      = rsp_if.day;
         got.consumed = rsp_if.consumed;
         got.ok       = rsp_if.ok;
         sb.check_response(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task send_byte(input logic [7:0] c, input logic first);
      while (!calm && $urandom_range(99) < 11) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.char_byte  <= c;
      req_if.first_byte <= first;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task send_text(input bit lead);
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], lead && i == 0);
   endtask

   task load_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task push_digits(input int n);
      repeat (n) text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   function logic [7:0] random_stop(input bit no_minus);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while ((b >= CHAR_ZERO && b <= CHAR_ZERO + DIGIT_MAX) || (no_minus && b == CHAR_MINUS))
         b = 8'($urandom_range(255));
      return b;
   endfunction

   // mostly short fields, now and then long enough to wrap the value
   function int random_len();
      return ($urandom_range(9) == 0) ? $urandom_range(15, 8) : $urandom_range(4);
   endfunction

   task build_date(input bit broken, input bit open_end);
      int bad;
      bad = broken ? $urandom_range(1, 2) : 0;
      for (int f = 0; f < 3; f++) begin
         if ($urandom_range(3) == 0) text_q.push_back(CHAR_MINUS);
         push_digits(random_len());
         if (f < 2) text_q.push_back((bad == f + 1) ? random_stop(1'b1) : CHAR_MINUS);
      end
      if (!open_end) text_q.push_back(random_stop(1'b0));
      repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(255)));
   endtask

   // hold off the sender until every date is back
   task drain_dates();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int start;
      int n;
      int kind;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // bytes ahead of any first flag are dropped
      load_text("12-3x");
      send_text(1'b0);
      load_text("2024-06-15T");
      send_text(1'b1);
      load_text("-0044-03--15 ");
      send_text(1'b1);
      load_text("----Z");
      send_text(1'b1);
      load_text("2024/06-01 ");
      send_text(1'b1);
      load_text("2024-06+01 ");
      send_text(1'b1);
      load_text("99999999999-4294967296--4294967297 ");
      send_text(1'b1);
      load_text("1-2-3Z456-7-8 ");
      send_text(1'b1);
      load_text("2024-06-1");
      send_text(1'b1);
      load_text("7-8-9.");
      send_text(1'b1);
      text_q = {8'hFF};
      send_text(1'b1);
      load_text("1-2-3");
      text_q.push_back(8'h00);
      send_text(1'b1);
      load_text("-");
      send_text(1'b1);
      load_text("0-0-0 ");
      send_text(1'b1);
      drain_dates();

      start = sb.parsed;
      n = 0;
      while (sb.parsed - start < 650) begin
         calm = (n >= 25 && n < 45);
         kind = $urandom_range(99);
         text_q.delete();
         if (kind < 70) begin
            build_date(1'b0, $urandom_range(9) == 0);
            send_text(1'b1);
         end else if (kind < 85) begin
            build_date(1'b1, 1'b0);
            send_text(1'b1);
         end else begin
            repeat ($urandom_range(1, 8))
               send_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
         end
         if (n == 60) drain_dates();
         n++;
      end
      calm = 1'b0;

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== extended_date_text_parser.f =====
hw/rtl/edtp_pkg.sv
hw/rtl/edtp_chan_if.sv
hw/rtl/extended_date_text_parser.sv
bench/testbench.sv
